// ----- hw/rtl/blr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  // fixed field widths of the ports
  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;

  // default stepper width; coordinates wrap modulo 2^COORD_BITS
  localparam int COORD_BITS_DEF = 6;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    logic load;   // latch a new line command
    logic step;   // advance to the next pixel
  } blr_cmd_t;

  typedef struct packed {
    logic zero_len;  // incoming command has coincident endpoints
    logic last;      // current pixel is the final one of the line
  } blr_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/blr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blr_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  blr_pkg::blr_status_t status,
  output blr_pkg::blr_cmd_t    cmd
);
  import blr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic in_acc;
  logic out_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RUN);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign cmd.load = in_acc;
  assign cmd.step = out_acc;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        // a zero-length line produces no beat, stay idle
        if (in_acc && !status.zero_len) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (out_acc && status.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/blr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blr_datapath #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  wire                  clk,
  input  blr_pkg::blr_cmd_t    cmd,
  output blr_pkg::blr_status_t status,
  input  blr_pkg::coord_t      in_x_start,
  input  blr_pkg::coord_t      in_y_start,
  input  blr_pkg::coord_t      in_x_end,
  input  blr_pkg::coord_t      in_y_end,
  input  blr_pkg::color_t      in_color,
  output blr_pkg::coord_t      out_pixel_x,
  output blr_pkg::coord_t      out_pixel_y,
  output blr_pkg::color_t      out_pixel_color,
  output logic                 out_last
);
  import blr_pkg::*;

  typedef logic [COORD_BITS-1:0]      pos_t;
  typedef logic signed [COORD_BITS:0] err_t;

  // stepper registers, loaded on an accepted command
  pos_t   major_pos_r;
  pos_t   major_end_r;
  pos_t   minor_pos_r;
  err_t   err_term_r;
  pos_t   delta_major_r;
  pos_t   delta_minor_r;
  logic   step_major_neg_r;
  logic   step_minor_neg_r;
  logic   axes_swapped_r;
  color_t color_r;

  // setup
  pos_t x0, y0, x1, y1;
  pos_t adx, ady;
  logic swap;
  pos_t maj0, maj1, min0, min1;
  pos_t dmaj, dmin;

  // step
  pos_t major_next;
  pos_t minor_next;
  err_t err_sub;
  err_t err_nxt;

  assign x0 = in_x_start[COORD_BITS-1:0];
  assign y0 = in_y_start[COORD_BITS-1:0];
  assign x1 = in_x_end[COORD_BITS-1:0];
  assign y1 = in_y_end[COORD_BITS-1:0];

  assign adx  = (x0 > x1) ? (x0 - x1) : (x1 - x0);
  assign ady  = (y0 > y1) ? (y0 - y1) : (y1 - y0);
  assign swap = (ady > adx);
  assign maj0 = swap ? y0 : x0;
  assign maj1 = swap ? y1 : x1;
  assign min0 = swap ? x0 : y0;
  assign min1 = swap ? x1 : y1;
  assign dmaj = swap ? ady : adx;
  assign dmin = swap ? adx : ady;

  assign status.zero_len = (dmaj == '0);

  assign major_next = step_major_neg_r ? (major_pos_r - pos_t'(1)) : (major_pos_r + pos_t'(1));
  assign minor_next = step_minor_neg_r ? (minor_pos_r - pos_t'(1)) : (minor_pos_r + pos_t'(1));
  assign err_sub    = err_term_r - err_t'({1'b0, delta_minor_r});
  // error went negative: minor axis moves and the major delta is added back
  assign err_nxt    = err_sub[COORD_BITS] ? (err_sub + err_t'({1'b0, delta_major_r})) : err_sub;

  assign status.last = (major_next == major_end_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      major_pos_r      <= maj0;
      major_end_r      <= maj1;
      minor_pos_r      <= min0;
      err_term_r       <= err_t'({1'b0, dmaj} >> 1);
      delta_major_r    <= dmaj;
      delta_minor_r    <= dmin;
      step_major_neg_r <= !(maj0 < maj1);
      step_minor_neg_r <= !(min0 < min1);
      axes_swapped_r   <= swap;
      color_r          <= in_color;
    end else if (cmd.step) begin
      major_pos_r <= major_next;
      err_term_r  <= err_nxt;
      if (err_sub[COORD_BITS]) begin
        minor_pos_r <= minor_next;
      end
    end
  end

  assign out_pixel_x     = coord_t'(axes_swapped_r ? minor_pos_r : major_pos_r);
  assign out_pixel_y     = coord_t'(axes_swapped_r ? major_pos_r : minor_pos_r);
  assign out_pixel_color = color_r;
  assign out_last        = status.last;

endmodule

`default_nettype wire

// ----- hw/rtl/bresenham_line_rasterizer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line rasterizer. Each accepted command (two endpoints and a colour)
// is stepped out as one pixel beat per cycle while out_stall is low, starting
// at the first endpoint and stopping one short of the second; out_last marks
// the final pixel, and a command with coincident endpoints yields no beat.
// Coordinates wrap modulo 2^COORD_BITS. A command yields one pixel beat per
// major-axis step (the major-axis delta, at most 2^COORD_BITS - 1), paced by
// the single stepper register set; the input stalls until the last pixel beat
// of the current line has been taken, so no new command overlaps a line.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  blr_pkg::coord_t in_x_start,
  input  blr_pkg::coord_t in_y_start,
  input  blr_pkg::coord_t in_x_end,
  input  blr_pkg::coord_t in_y_end,
  input  blr_pkg::color_t in_color,
  output logic            out_valid,
  input  wire             out_stall,
  output blr_pkg::coord_t out_pixel_x,
  output blr_pkg::coord_t out_pixel_y,
  output blr_pkg::color_t out_pixel_color,
  output logic            out_last
);
  import blr_pkg::*;

  blr_cmd_t    cmd;
  blr_status_t status;

  blr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  blr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .status          (status),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_color        (in_color),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
